@@ src/srgblab_pkg.sv @@
// Shared types, constants and constant tables for the sRGB to L*a*b* converter.
`timescale 1ns / 1ps
package srgblab_pkg;

  // Output precision and internal fixed point format.
  localparam int FRAC_BITS   = 16;
  localparam int L_W         = FRAC_BITS + 1;
  localparam int C_W         = FRAC_BITS + 2;
  localparam int Q           = 30;
  localparam int LIN_W       = Q + 1;
  localparam int CBRT_STAGES = Q + 1;
  localparam int KM_W        = 27;
  localparam int XW          = LIN_W + 2;
  localparam int PW          = 67;
  localparam int RS          = 2 * Q - FRAC_BITS;
  localparam int AS          = Q - FRAC_BITS;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register map.
  localparam int ADDR_W = 3;
  localparam logic REG_COLOR_MODE = 1'b0;

  // Color mode codes.
  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_RGB  = 2'd1;
  localparam logic [1:0] MODE_RGBA = 2'd2;

  localparam longint unsigned Q_ONE  = 64'd1073741824;
  localparam longint unsigned Q_HALF = 64'd536870912;

  // Decimal constant in units of 1e-9, rounded to the nearest Q30 value.
  function automatic longint unsigned qc(longint unsigned d);
    return (d * Q_ONE + 64'd500000000) / 64'd1000000000;
  endfunction

  localparam longint unsigned C_XR   = qc(64'd433936244);
  localparam longint unsigned C_XG   = qc(64'd376197791);
  localparam longint unsigned C_XB   = qc(64'd189834298);
  localparam longint unsigned C_YR   = qc(64'd212672900);
  localparam longint unsigned C_YG   = qc(64'd715152200);
  localparam longint unsigned C_YB   = qc(64'd72175000);
  localparam longint unsigned C_ZR   = qc(64'd17753811);
  localparam longint unsigned C_ZG   = qc(64'd109450872);
  localparam longint unsigned C_ZB   = qc(64'd872639210);
  localparam longint unsigned C_EPS  = qc(64'd8856452);
  localparam longint unsigned C_S    = qc(64'd137931034);
  localparam longint unsigned C_K    = qc(64'd7787037037);
  localparam longint unsigned C_L    = qc(64'd1160000000);
  localparam longint unsigned C_AOFF = qc(64'd391818182);
  localparam longint unsigned C_AMUL = qc(64'd2272727273);
  localparam longint unsigned C_BOFF = qc(64'd490454545);
  localparam longint unsigned C_BMUL = qc(64'd909090909);

  // One pixel as it travels from the front to the back.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } item_t;

  typedef logic [LIN_W-1:0] gamma_rom_t [256];
  typedef logic [L_W-1:0]   gray_rom_t  [256];

  // sRGB gamma curve for one 8-bit code, in Q30.
  function automatic logic [LIN_W-1:0] gamma_entry(longint unsigned v);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned r;
    longint unsigned c;
    longint unsigned p;
    if (v <= 64'd10) begin
      return LIN_W'((v * 64'd100 * Q_ONE + 64'd164730) / 64'd329460);
    end
    t  = ((v * 64'd1000 + 64'd14025) * Q_ONE + 64'd134512) / 64'd269025;
    t2 = (t * t + Q_HALF) >> Q;
    r  = 64'd0;
    if (t2 >= Q_ONE) begin
      r = Q_ONE;
    end else begin
      for (int b = Q - 1; b >= 0; b--) begin
        c = r | (64'd1 << b);
        p = (c * c) >> Q;
        p = (p * c) >> Q;
        p = (p * c) >> Q;
        p = (p * c) >> Q;
        if (p <= t2) r = c;
      end
    end
    return LIN_W'((t2 * r + Q_HALF) >> Q);
  endfunction

  function automatic gamma_rom_t build_gamma();
    gamma_rom_t rom;
    for (int v = 0; v < 256; v++) begin
      rom[v] = gamma_entry(longint'(v));
    end
    return rom;
  endfunction

  // Gray sample divided by 255, rounded, with FRAC_BITS fraction bits.
  function automatic gray_rom_t build_gray();
    gray_rom_t rom;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      v = longint'(i);
      rom[i] = L_W'(((v << (FRAC_BITS + 1)) + 64'd255) / 64'd510);
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();
  localparam gray_rom_t  GRAY_ROM  = build_gray();

endpackage

@@ src/srgblab_front.sv @@
// Input stage: takes pixel transfers, blends over gray in RGBA mode, feeds the queue.
`timescale 1ns / 1ps
module srgblab_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic [7:0]          alpha,
  input  logic [1:0]          color_mode,
  input  logic                queue_full,
  output logic                push,
  output srgblab_pkg::item_t  push_item
);
  import srgblab_pkg::*;

  logic  held;
  item_t raw;

  // floor((a*c + (255-a)*128) / 255) through a reciprocal multiply.
  function automatic logic [7:0] blend(logic [7:0] c, logic [7:0] a);
    logic [15:0] x;
    logic [16:0] x1;
    logic [24:0] y;
    x  = 16'(a) * 16'(c) + {1'b0, 8'd255 - a, 7'b0};
    x1 = 17'(x) + 17'd1;
    y  = {x1, 8'b0} + 25'(x1);
    return y[23:16];
  endfunction

  assign pixel_ready = !held || !queue_full;
  assign push        = held && !queue_full;

  // Hold one pixel until the queue takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (pixel_ready) begin
      held <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      raw <= '{mode: color_mode, red: red, green: green, blue: blue, alpha: alpha};
    end
  end

  // Blend the color channels only in RGBA mode.
  always_comb begin
    push_item = raw;
    if (raw.mode == MODE_RGBA) begin
      push_item.red   = blend(raw.red, raw.alpha);
      push_item.green = blend(raw.green, raw.alpha);
      push_item.blue  = blend(raw.blue, raw.alpha);
    end
  end

endmodule

@@ src/srgblab_queue.sv @@
// Short queue that decouples the front from the back.
`timescale 1ns / 1ps
module srgblab_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  srgblab_pkg::item_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                filled,
  output srgblab_pkg::item_t  head
);
  import srgblab_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full   = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign filled = (count != '0);
  assign head   = slots[rd_ptr];
  assign do_pop = pop && filled;

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

@@ src/srgblab_cbrt.sv @@
// Pipelined cube root, one result bit per stage, Q30 in and out.
`timescale 1ns / 1ps
module srgblab_cbrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [srgblab_pkg::LIN_W-1:0] radicand,
  output logic [srgblab_pkg::LIN_W-1:0] root
);
  import srgblab_pkg::*;

  logic [LIN_W-1:0]   f_q  [CBRT_STAGES-1];
  logic [LIN_W-1:0]   r_q  [CBRT_STAGES];
  logic [2*LIN_W-1:0] sq_q [CBRT_STAGES-1];

  for (genvar k = 0; k < CBRT_STAGES; k++) begin : g_stage
    localparam int B = CBRT_STAGES - 1 - k;
    logic [LIN_W-1:0]   f_in;
    logic [LIN_W-1:0]   r_in;
    logic [2*LIN_W-1:0] sq_in;
    logic [LIN_W-1:0]   cand;
    logic [2*LIN_W-1:0] sq_try;
    logic [LIN_W:0]     sq_t;
    logic [2*LIN_W:0]   cube;
    logic               take;

    if (k == 0) begin : g_first
      assign f_in  = radicand;
      assign r_in  = '0;
      assign sq_in = '0;
    end else begin : g_next
      assign f_in  = f_q[k-1];
      assign r_in  = r_q[k-1];
      assign sq_in = sq_q[k-1];
    end

    // The exact square grows by shifts and adds; only the cube needs a multiplier.
    assign cand   = r_in | (LIN_W'(1) << B);
    assign sq_try = sq_in + ((2 * LIN_W)'(r_in) << (B + 1)) + ((2 * LIN_W)'(1) << (2 * B));
    assign sq_t   = sq_try[2*LIN_W-1:Q];
    assign cube   = sq_t * cand;
    assign take   = (cube[2*LIN_W:Q] <= (LIN_W + 2)'(f_in));

    always_ff @(posedge clk) begin
      if (en) r_q[k] <= take ? cand : r_in;
    end

    if (k < CBRT_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          f_q[k]  <= f_in;
          sq_q[k] <= take ? sq_try : sq_in;
        end
      end
    end
  end

  assign root = r_q[CBRT_STAGES-1];

endmodule

@@ src/srgblab_back.sv @@
// Conversion pipeline: gamma, D65 matrix, cube root curve, L*a*b* and the result register.
`timescale 1ns / 1ps
module srgblab_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               filled,
  input  srgblab_pkg::item_t                 head,
  output logic                               pop,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic        [srgblab_pkg::L_W-1:0] lightness,
  output logic signed [srgblab_pkg::C_W-1:0] chroma_a,
  output logic signed [srgblab_pkg::C_W-1:0] chroma_b,
  output logic        [srgblab_pkg::L_W-1:0] alpha_linear
);
  import srgblab_pkg::*;

  typedef struct packed {
    logic [1:0]      mode;
    logic [L_W-1:0]  gray;
    logic [L_W-1:0]  alin;
    logic [2:0]      low;
    logic [KM_W-1:0] km_x;
    logic [KM_W-1:0] km_y;
    logic [KM_W-1:0] km_z;
  } side_t;

  localparam logic [LIN_W-1:0] COEF [9] = '{
    LIN_W'(C_XR), LIN_W'(C_XG), LIN_W'(C_XB),
    LIN_W'(C_YR), LIN_W'(C_YG), LIN_W'(C_YB),
    LIN_W'(C_ZR), LIN_W'(C_ZG), LIN_W'(C_ZB)
  };
  localparam logic signed [XW-1:0] S_Q     = XW'(C_S);
  localparam logic        [33:0]   K_MUL   = 34'(C_K);
  localparam logic signed [PW-1:0] L_MUL   = PW'(C_L);
  localparam logic signed [PW-1:0] A_MUL   = PW'(C_AMUL);
  localparam logic signed [PW-1:0] B_MUL   = PW'(C_BMUL);
  localparam logic signed [PW-1:0] A_OFF   = PW'(C_AOFF) << Q;
  localparam logic signed [PW-1:0] B_OFF   = PW'(C_BOFF) << Q;
  localparam logic signed [PW-1:0] RND     = PW'(1) << (RS - 1);
  localparam logic signed [PW-1:0] ONE     = PW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] C_MAX   = (PW'(1) << (FRAC_BITS + 1)) - PW'(1);
  localparam logic signed [PW-1:0] C_MIN   = -(PW'(1) << (FRAC_BITS + 1));

  logic en;

  // Stage 0: gamma lookups.
  logic             v0;
  logic [LIN_W-1:0] lin0 [3];
  logic [1:0]       mode0;
  logic [L_W-1:0]   gray0;
  logic [L_W-1:0]   alin0;
  logic [LIN_W:0]   alin_sum;

  // Stage 1: matrix products.
  logic               v1;
  logic [2*LIN_W-1:0] prod1 [9];
  logic [1:0]         mode1;
  logic [L_W-1:0]     gray1;
  logic [L_W-1:0]     alin1;

  // Stage 2: X, Y, Z sums.
  logic             v2;
  logic [LIN_W-1:0] f2 [3];
  logic [1:0]       mode2;
  logic [L_W-1:0]   gray2;
  logic [L_W-1:0]   alin2;

  // Side line that runs beside the cube root stages.
  side_t            side_in;
  side_t            side_q [CBRT_STAGES];
  logic             vline  [CBRT_STAGES];
  logic [LIN_W-1:0] root   [3];
  logic [64:0]      km_sum [3];

  // Curve values and products.
  logic                   v3;
  logic signed [XW-1:0]   xyz3 [3];
  side_t                  side3;
  logic                   v4;
  logic signed [PW-1:0]   pl4;
  logic signed [PW-1:0]   pa4;
  logic signed [PW-1:0]   pb4;
  side_t                  side4;
  logic signed [PW-1:0]   l_full;
  logic signed [PW-1:0]   a_full;
  logic signed [PW-1:0]   b_full;
  logic        [L_W-1:0]  l_sat;
  logic signed [C_W-1:0]  a_sat;
  logic signed [C_W-1:0]  b_sat;

  // The whole pipeline advances unless a finished result is waiting.
  assign en  = !result_valid || result_ready;
  assign pop = en && filled;

  assign alin_sum = {1'b0, GAMMA_ROM[head.alpha]} + ((LIN_W + 1)'(1) << (AS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      lin0[0] <= GAMMA_ROM[head.red];
      lin0[1] <= GAMMA_ROM[head.green];
      lin0[2] <= GAMMA_ROM[head.blue];
      mode0   <= head.mode;
      gray0   <= GRAY_ROM[head.red];
      alin0   <= alin_sum[Q:AS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        prod1[i] <= lin0[i%3] * COEF[i];
      end
      mode1 <= mode0;
      gray1 <= gray0;
      alin1 <= alin0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        f2[j] <= LIN_W'((64'(prod1[3*j]) + 64'(prod1[3*j+1]) + 64'(prod1[3*j+2])
                         + 64'(Q_HALF)) >> Q);
      end
      mode2 <= mode1;
      gray2 <= gray1;
      alin2 <= alin1;
    end
  end

  // Cube roots of X, Y and Z.
  for (genvar j = 0; j < 3; j++) begin : g_root
    srgblab_cbrt u_cbrt (
      .clk      (clk),
      .en       (en),
      .radicand (f2[j]),
      .root     (root[j])
    );
    assign km_sum[j] = 65'(K_MUL) * 65'(f2[j]) + 65'(Q_HALF);
  end

  // Linear segment and the choice between the two parts of the curve.
  always_comb begin
    side_in.mode   = mode2;
    side_in.gray   = gray2;
    side_in.alin   = alin2;
    side_in.low[0] = (64'(f2[0]) <= C_EPS);
    side_in.low[1] = (64'(f2[1]) <= C_EPS);
    side_in.low[2] = (64'(f2[2]) <= C_EPS);
    side_in.km_x   = km_sum[0][Q+KM_W-1:Q];
    side_in.km_y   = km_sum[1][Q+KM_W-1:Q];
    side_in.km_z   = km_sum[2][Q+KM_W-1:Q];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < CBRT_STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < CBRT_STAGES; i++) vline[i] <= 1'b0;
    end else if (en) begin
      v0 <= filled;
      v1 <= v0;
      v2 <= v1;
      vline[0] <= v2;
      for (int i = 1; i < CBRT_STAGES; i++) vline[i] <= vline[i-1];
      v3 <= vline[CBRT_STAGES-1];
      v4 <= v3;
      result_valid <= v4;
    end
  end

  // Curve: cube root minus 4/29 above epsilon, k*v at or below.
  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side_q[CBRT_STAGES-1];
      xyz3[0] <= side_q[CBRT_STAGES-1].low[0] ?
                 XW'(side_q[CBRT_STAGES-1].km_x) : XW'(root[0]) - S_Q;
      xyz3[1] <= side_q[CBRT_STAGES-1].low[1] ?
                 XW'(side_q[CBRT_STAGES-1].km_y) : XW'(root[1]) - S_Q;
      xyz3[2] <= side_q[CBRT_STAGES-1].low[2] ?
                 XW'(side_q[CBRT_STAGES-1].km_z) : XW'(root[2]) - S_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side3;
      pl4   <= L_MUL * PW'(xyz3[1]);
      pa4   <= A_MUL * (PW'(xyz3[0]) - PW'(xyz3[1]));
      pb4   <= B_MUL * (PW'(xyz3[1]) - PW'(xyz3[2]));
    end
  end

  // Round to the output precision and saturate.
  always_comb begin
    l_full = (pl4 + RND) >>> RS;
    a_full = (A_OFF + pa4 + RND) >>> RS;
    b_full = (B_OFF + pb4 + RND) >>> RS;
    priority if (l_full < 0) begin
      l_sat = '0;
    end else if (l_full > ONE) begin
      l_sat = L_W'(ONE);
    end else begin
      l_sat = L_W'(l_full);
    end
    priority if (a_full < C_MIN) begin
      a_sat = C_W'(C_MIN);
    end else if (a_full > C_MAX) begin
      a_sat = C_W'(C_MAX);
    end else begin
      a_sat = C_W'(a_full);
    end
    priority if (b_full < C_MIN) begin
      b_sat = C_W'(C_MIN);
    end else if (b_full > C_MAX) begin
      b_sat = C_W'(C_MAX);
    end else begin
      b_sat = C_W'(b_full);
    end
  end

  // Result register; the mode picks which fields carry data.
  always_ff @(posedge clk) begin
    if (en && v4) begin
      priority if (side4.mode == MODE_GRAY) begin
        lightness    <= side4.gray;
        chroma_a     <= '0;
        chroma_b     <= '0;
        alpha_linear <= '0;
      end else if (side4.mode == MODE_RGBA) begin
        lightness    <= l_sat;
        chroma_a     <= a_sat;
        chroma_b     <= b_sat;
        alpha_linear <= side4.alin;
      end else begin
        lightness    <= l_sat;
        chroma_a     <= a_sat;
        chroma_b     <= b_sat;
        alpha_linear <= '0;
      end
    end
  end

endmodule

@@ src/srgb_pixel_to_lab_convert.sv @@
// Top level of the sRGB(A) pixel to L*a*b* converter with its register port.
// One pixel per clock unless the output stalls; the 31-stage cube root sets the latency.
// A four-entry queue lets the input keep taking pixels while a result waits.
// Reset (rst, synchronous) empties the pipeline and queue and sets color_mode to RGB.
`timescale 1ns / 1ps
module srgb_pixel_to_lab_convert (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [srgblab_pkg::ADDR_W-1:0] paddr,
  input  logic        [31:0]                   pwdata,
  output logic        [31:0]                   prdata,
  output logic                                 pready,
  input  logic                                 pixel_valid,
  output logic                                 pixel_ready,
  input  logic        [7:0]                    red,
  input  logic        [7:0]                    green,
  input  logic        [7:0]                    blue,
  input  logic        [7:0]                    alpha,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic        [srgblab_pkg::L_W-1:0]   lightness,
  output logic signed [srgblab_pkg::C_W-1:0]   chroma_a,
  output logic signed [srgblab_pkg::C_W-1:0]   chroma_b,
  output logic        [srgblab_pkg::L_W-1:0]   alpha_linear
);
  import srgblab_pkg::*;

  logic [1:0] color_mode;
  logic       queue_full;
  logic       push;
  item_t      push_item;
  logic       pop;
  logic       filled;
  item_t      head;

  assign pready = 1'b1;

  // Register write on the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= MODE_RGB;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_COLOR_MODE) begin
      color_mode <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_COLOR_MODE) ? {30'b0, color_mode} : 32'b0;

  srgblab_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .color_mode  (color_mode),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  srgblab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .filled    (filled),
    .head      (head)
  );

  srgblab_back u_back (
    .clk          (clk),
    .rst          (rst),
    .filled       (filled),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .lightness    (lightness),
    .chroma_a     (chroma_a),
    .chroma_b     (chroma_b),
    .alpha_linear (alpha_linear)
  );

endmodule

@@ src/srgblab_check.sv @@
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
module srgblab_check (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic        [srgblab_pkg::ADDR_W-1:0] paddr,
  input logic        [31:0]                   pwdata,
  input logic        [31:0]                   prdata,
  input logic                                 pready,
  input logic                                 pixel_ready,
  input logic                                 result_valid,
  input logic                                 result_ready,
  input logic        [srgblab_pkg::L_W-1:0]   lightness,
  input logic signed [srgblab_pkg::C_W-1:0]   chroma_a,
  input logic signed [srgblab_pkg::C_W-1:0]   chroma_b,
  input logic        [srgblab_pkg::L_W-1:0]   alpha_linear
);

  // A stalled result holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(lightness)
      && $stable(chroma_a) && $stable(chroma_b) && $stable(alpha_linear))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // After reset the input side is free to take a transfer.
  a_reset_ready: assert property (@(posedge clk) rst |=> pixel_ready)
    else $error("input not ready after reset");

  // A written mode reads back on the next cycle.
  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && !paddr[2]) ##1
      (psel && !pwrite && !paddr[2]) |-> prdata == {30'b0, $past(pwdata[1:0])})
    else $error("color mode read back differs from the write");

endmodule

bind srgb_pixel_to_lab_convert srgblab_check u_check (.*);

@@ sim/tb_srgb_pixel_to_lab_convert.sv @@
// Self-checking testbench for the sRGB(A) pixel to L*a*b* converter.
`timescale 1ns / 1ps
module tb_srgb_pixel_to_lab_convert;
  import srgblab_pkg::*;

  // Mode value three has no name in the package; the block treats it as RGB.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_MODE   = ADDR_W'(4 * REG_COLOR_MODE);
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(4);
  localparam int PIPE_CYCLES  = 45;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 165;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    logic [L_W-1:0]        l;
    logic signed [C_W-1:0] ca;
    logic signed [C_W-1:0] cb;
    logic [L_W-1:0]        al;
  } lab_t;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    bit         typed;
    lab_t       res;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic [7:0] alpha = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [L_W-1:0] lightness;
  logic signed [C_W-1:0] chroma_a;
  logic signed [C_W-1:0] chroma_b;
  logic [L_W-1:0] alpha_linear;

  srgb_pixel_to_lab_convert i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .result_valid(result_valid), .result_ready(result_ready),
    .lightness(lightness), .chroma_a(chroma_a), .chroma_b(chroma_b),
    .alpha_linear(alpha_linear)
  );

  longint unsigned linear_lut [256];
  lab_t expected_lab [$];
  logic [1:0] cur_mode;
  int mismatches = 0;
  int results_seen = 0;
  int burst_left = 0;
  bit long_hold_req = 1'b0;
  int mode_hits [4];

  initial begin
    forever #4 clk = ~clk;
  end

  // Safety net for a hung handshake.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // sRGB decoding of one 8-bit code into Q30 linear light.
  function automatic longint unsigned srgb_to_linear(longint unsigned v);
    longint unsigned t, t2, root, cand, pw;
    if (v <= 10) return (v * 100 * Q_ONE + 164730) / 329460;
    t = ((v * 1000 + 14025) * Q_ONE + 134512) / 269025;
    t2 = (t * t + Q_HALF) >> 30;
    root = 0;
    if (t2 >= Q_ONE) begin
      root = Q_ONE;
    end else begin
      for (int k = 29; k >= 0; k--) begin
        cand = root | (64'd1 << k);
        pw = (cand * cand) >> 30;
        for (int j = 0; j < 3; j++) pw = (pw * cand) >> 30;
        if (pw <= t2) root = cand;
      end
    end
    return (t2 * root + Q_HALF) >> 30;
  endfunction

  // Lab companding: cube root above the knee, linear slope below it.
  function automatic longint lab_compand(longint unsigned f);
    longint unsigned root, cand;
    if (f <= C_EPS) return longint'((C_K * f + Q_HALF) >> 30);
    root = 0;
    for (int k = 30; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      if ((((cand * cand) >> 30) * cand >> 30) <= f) root = cand;
    end
    return longint'(root) - longint'(C_S);
  endfunction

  function automatic longint round_down_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [7:0] blend_over_gray(logic [7:0] c, logic [7:0] a);
    return 8'((int'(a) * int'(c) + (255 - int'(a)) * 128) / 255);
  endfunction

  // Expected L*a*b* result of one pixel under the given mode.
  function automatic lab_t predict_lab(logic [1:0] mode, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b, logic [7:0] a);
    lab_t res;
    longint unsigned lr, lg, lb, fx, fy, fz;
    longint vx, vy, vz, lv, av, bv;
    longint one;
    one = longint'(1) << FRAC_BITS;
    res.l = '0; res.ca = '0; res.cb = '0; res.al = '0;
    if (mode == MODE_GRAY) begin
      res.l = L_W'(((longint'(r) << (FRAC_BITS + 1)) + 255) / 510);
      return res;
    end
    if (mode == MODE_RGBA) begin
      r = blend_over_gray(r, a);
      g = blend_over_gray(g, a);
      b = blend_over_gray(b, a);
      res.al = L_W'(round_down_shift(longint'(linear_lut[a]), 30 - FRAC_BITS));
    end
    lr = linear_lut[r]; lg = linear_lut[g]; lb = linear_lut[b];
    fx = (C_XR * lr + C_XG * lg + C_XB * lb + Q_HALF) >> 30;
    fy = (C_YR * lr + C_YG * lg + C_YB * lb + Q_HALF) >> 30;
    fz = (C_ZR * lr + C_ZG * lg + C_ZB * lb + Q_HALF) >> 30;
    vx = lab_compand(fx); vy = lab_compand(fy); vz = lab_compand(fz);
    lv = round_down_shift(longint'(C_L) * vy, 60 - FRAC_BITS);
    av = round_down_shift((longint'(C_AOFF) <<< 30) + longint'(C_AMUL) * (vx - vy),
                          60 - FRAC_BITS);
    bv = round_down_shift((longint'(C_BOFF) <<< 30) + longint'(C_BMUL) * (vy - vz),
                          60 - FRAC_BITS);
    res.l  = L_W'(saturate(lv, 0, one));
    res.ca = C_W'(saturate(av, -2 * one, 2 * one - 1));
    res.cb = C_W'(saturate(bv, -2 * one, 2 * one - 1));
    return res;
  endfunction

  // Register write: setup cycle, then access cycle.
  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_MODE) cur_mode = data[1:0];
  endtask

  task automatic reg_read_check(logic [ADDR_W-1:0] addr, logic [31:0] want);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[1:0] !== want[1:0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("color_mode readback: expected %0d got %0d", want[1:0], prdata[1:0]);
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // Let the pipeline run dry before touching the register.
  task automatic drain_pipeline();
    pixel_valid <= 1'b0;
    burst_left = 0;
    while (expected_lab.size() > 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] mode);
    drain_pipeline();
    reg_write(ADDR_MODE, 32'(mode));
  endtask

  // Offer one pixel in bursts with random gaps; record its prediction on transfer.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                            bit typed, lab_t typed_res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    red <= r; green <= g; blue <= b; alpha <= a;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (!pixel_ready);
    expected_lab.push_back(typed ? typed_res : predict_lab(cur_mode, r, g, b, a));
    mode_hits[cur_mode]++;
    burst_left--;
  endtask

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 12));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver stall pattern, plus one long hold-off on request.
  initial begin
    int pct;
    int hold_cnt;
    pct = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        result_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(posedge clk);
        long_hold_req = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 25;
          default: pct = 75;
        endcase
      end
      result_ready <= ($urandom_range(0, 99) >= pct);
    end
  end

  // Result checker against the oldest prediction.
  always @(posedge clk) begin
    lab_t exp_res;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (expected_lab.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: L=%0d", lightness);
      end else begin
        exp_res = expected_lab.pop_front();
        if (lightness !== exp_res.l || chroma_a !== exp_res.ca ||
            chroma_b !== exp_res.cb || alpha_linear !== exp_res.al) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected L=%0d a=%0d b=%0d al=%0d got L=%0d a=%0d b=%0d al=%0d",
                     results_seen, exp_res.l, exp_res.ca, exp_res.cb, exp_res.al,
                     lightness, chroma_a, chroma_b, alpha_linear);
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases over all modes.
  initial begin
    pixel_row_t rows [$];
    pixel_row_t row;
    lab_t zero_res, white_gray;
    logic [1:0] phase_modes [RAND_PHASES];
    lab_t dummy;

    for (int v = 0; v < 256; v++) linear_lut[v] = srgb_to_linear(longint'(v));
    zero_res = '{l: '0, ca: '0, cb: '0, al: '0};
    white_gray = zero_res;
    white_gray.l = L_W'(1 << FRAC_BITS);
    dummy = zero_res;
    cur_mode = MODE_RGB;

    // Grayscale: the extremes are known outright; other channels are ignored.
    rows.push_back('{MODE_GRAY, 8'd0,   8'd255, 8'd255, 8'd255, 1'b1, zero_res});
    rows.push_back('{MODE_GRAY, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1, white_gray});
    rows.push_back('{MODE_GRAY, 8'd1,   8'd7,   8'd9,   8'd3,   1'b0, dummy});
    rows.push_back('{MODE_GRAY, 8'd128, 8'd255, 8'd0,   8'd255, 1'b0, dummy});
    // RGB: black, white, primaries, the linear gamma segment edge, alpha ignored.
    rows.push_back('{MODE_RGB, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, dummy});
    rows.push_back('{MODE_RGB, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, dummy});
    rows.push_back('{MODE_RGB, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, dummy});
    rows.push_back('{MODE_RGB, 8'd0,   8'd255, 8'd0,   8'd0,   1'b0, dummy});
    rows.push_back('{MODE_RGB, 8'd0,   8'd0,   8'd255, 8'd0,   1'b0, dummy});
    rows.push_back('{MODE_RGB, 8'd10,  8'd10,  8'd10,  8'd0,   1'b0, dummy});
    rows.push_back('{MODE_RGB, 8'd11,  8'd11,  8'd11,  8'd255, 1'b0, dummy});
    rows.push_back('{MODE_RGB, 8'd1,   8'd2,   8'd3,   8'd0,   1'b0, dummy});
    // RGBA: fully transparent, fully opaque, half blend, nearly transparent.
    rows.push_back('{MODE_RGBA, 8'd255, 8'd255, 8'd255, 8'd0,   1'b0, dummy});
    rows.push_back('{MODE_RGBA, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, dummy});
    rows.push_back('{MODE_RGBA, 8'd255, 8'd0,   8'd0,   8'd255, 1'b0, dummy});
    rows.push_back('{MODE_RGBA, 8'd0,   8'd255, 8'd128, 8'd128, 1'b0, dummy});
    rows.push_back('{MODE_RGBA, 8'd200, 8'd50,  8'd10,  8'd10,  1'b0, dummy});
    rows.push_back('{MODE_RGBA, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, dummy});
    // Spare mode code behaves like RGB.
    rows.push_back('{MODE_SPARE, 8'd255, 8'd0,   8'd255, 8'd77, 1'b0, dummy});
    rows.push_back('{MODE_SPARE, 8'd0,   8'd255, 8'd0,   8'd0,  1'b0, dummy});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_read_check(ADDR_MODE, 32'(MODE_RGB));

    foreach (rows[i]) begin
      row = rows[i];
      if (row.mode != cur_mode) set_mode(row.mode);
      send_pixel(row.r, row.g, row.b, row.a, row.typed, row.res);
    end

    // A write outside the register map must leave color_mode alone.
    drain_pipeline();
    reg_write(ADDR_UNUSED, 32'(MODE_GRAY));
    @(posedge clk);
    reg_read_check(ADDR_MODE, 32'(cur_mode));

    phase_modes = '{MODE_GRAY, MODE_RGB, MODE_RGBA, MODE_SPARE,
                    MODE_RGBA, MODE_RGB, MODE_GRAY, MODE_RGBA};
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_mode(phase_modes[p]);
      if (p == 2) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_pixel(pick_sample(), pick_sample(), pick_sample(), pick_sample(), 1'b0, dummy);
    end

    pixel_valid <= 1'b0;
    while (expected_lab.size() > 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d gray, %0d RGB, %0d RGBA, %0d spare-mode pixels.",
             results_seen, mode_hits[MODE_GRAY], mode_hits[MODE_RGB],
             mode_hits[MODE_RGBA], mode_hits[MODE_SPARE]);
    $display("Mismatches: %0d; one long output stall applied.", mismatches);
    if (mismatches == 0 && expected_lab.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ srgb_pixel_to_lab_convert.f @@
src/srgblab_pkg.sv
src/srgblab_front.sv
src/srgblab_queue.sv
src/srgblab_cbrt.sv
src/srgblab_back.sv
src/srgb_pixel_to_lab_convert.sv
src/srgblab_check.sv
sim/tb_srgb_pixel_to_lab_convert.sv
